FILE: rtl/skbs_pkg.sv
// Shared constants and command codes for the sorted key binary search block.
`timescale 1ns / 1ps
`default_nettype none

package skbs_pkg;

  localparam int MAX_KEYS_DEF = 16;
  localparam int KEY_W        = 32;
  localparam int CMD_W        = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SEARCH = 2'd2
  } skbs_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/skbs_key_mem.sv
// Key storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module skbs_key_mem
  import skbs_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  localparam int ADDR_W  = $clog2(MAX_KEYS)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [KEY_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [KEY_W-1:0]  rd_data
);

  logic [KEY_W-1:0] mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/skbs_ctrl.sv
// Command sequencer: key count, appends, and the halving search over the key memory.
`timescale 1ns / 1ps
`default_nettype none

module skbs_ctrl
  import skbs_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  localparam int ADDR_W  = $clog2(MAX_KEYS),
  localparam int CNT_W   = $clog2(MAX_KEYS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  command,
  input  logic [KEY_W-1:0]  key_value,
  output logic              done,
  output logic [CNT_W-1:0]  position,
  output logic              found,
  output logic              rejected,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [KEY_W-1:0]  wr_data,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [KEY_W-1:0]  rd_data
);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_KEYS);

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [ADDR_W-1:0] mid;
  logic [KEY_W-1:0]  target;

  logic              accept;
  logic              hit;
  logic              less;
  logic [CNT_W-1:0]  lo_next;
  logic [CNT_W-1:0]  hi_next;
  logic [CNT_W-1:0]  span;
  logic [ADDR_W-1:0] mid_next;

  assign busy   = (state == ST_SEARCH);
  assign accept = start && !busy;

  // The word read this cycle is the key at mid, addressed on the previous edge.
  always_comb begin
    hit      = (target == rd_data);
    less     = (target < rd_data);
    lo_next  = less ? lo : CNT_W'(mid) + CNT_W'(1);
    hi_next  = less ? CNT_W'(mid) : hi;
    span     = hi_next - lo_next;
    mid_next = ADDR_W'(lo_next + (span >> 1));
  end

  assign rd_addr = busy ? mid_next : ADDR_W'(count >> 1);
  assign wr_en   = accept && (command == CMD_APPEND) && (count < FULL_CNT);
  assign wr_addr = count[ADDR_W-1:0];
  assign wr_data = key_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            found    <= 1'b0;
            rejected <= 1'b0;
            case (skbs_cmd_t'(command))
              CMD_CLEAR: begin
                count    <= '0;
                position <= '0;
                done     <= 1'b1;
              end
              CMD_APPEND: begin
                if (count < FULL_CNT) begin
                  count    <= count + CNT_W'(1);
                  position <= count + CNT_W'(1);
                end else begin
                  position <= count;
                  rejected <= 1'b1;
                end
                done <= 1'b1;
              end
              CMD_SEARCH: begin
                target <= key_value;
                if (count == '0) begin
                  position <= '0;
                  done     <= 1'b1;
                end else begin
                  lo    <= '0;
                  hi    <= count;
                  mid   <= ADDR_W'(count >> 1);
                  state <= ST_SEARCH;
                end
              end
              default: begin
                position <= count;
                done     <= 1'b1;
              end
            endcase
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            position <= CNT_W'(mid);
            found    <= 1'b1;
            rejected <= 1'b0;
            done     <= 1'b1;
            state    <= ST_IDLE;
          end else if (lo_next == hi_next) begin
            position <= lo_next;
            found    <= 1'b0;
            rejected <= 1'b0;
            done     <= 1'b1;
            state    <= ST_IDLE;
          end else begin
            lo  <= lo_next;
            hi  <= hi_next;
            mid <= mid_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_key_binary_search.sv
// Top level of the sorted key binary search block.
//
// One leaf node of up to MAX_KEYS ascending 32-bit keys. A command word is
// taken on a rising edge where start is high and busy is low. Clear empties
// the node, append stores key_value at the end, search looks for key_value.
// Each command gives exactly one result, shown with done high for a single
// cycle; the receiver must take it then, as it cannot stall the block.
// Clear, append and the unused command code show done in the cycle right
// after the word is taken, and start may be asserted again in that same cycle.
// A search reads one key from the key memory per cycle and keeps busy high
// until its last probe, and done is shown in the cycle after the last probe.
// A search of an empty node makes no probe and never raises busy.
// The single read port of the key memory sets the search rate.
// position is the match index or the insertion index for a search, and the
// key count after the command otherwise. An append to a full node sets
// rejected. Reset empties the node and drops busy and done.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_binary_search
  import skbs_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [CMD_W-1:0]                 command,
  input  logic [KEY_W-1:0]                 key_value,
  output logic                             done,
  output logic [$clog2(MAX_KEYS + 1)-1:0]  position,
  output logic                             found,
  output logic                             rejected
);

  localparam int ADDR_W = $clog2(MAX_KEYS);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  rd_data;

  skbs_ctrl #(
    .MAX_KEYS(MAX_KEYS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .key_value(key_value),
    .done     (done),
    .position (position),
    .found    (found),
    .rejected (rejected),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  skbs_key_mem #(
    .MAX_KEYS(MAX_KEYS)
  ) u_key_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

`default_nettype wire

FILE: rtl/skbs_checker.sv
// Port-level assertions for the sorted key binary search block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module skbs_checker
  import skbs_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic [CMD_W-1:0]                command,
  input logic                            done,
  input logic [$clog2(MAX_KEYS + 1)-1:0] position,
  input logic                            found,
  input logic                            rejected
);

  // Reset leaves no search running and no word pending.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy or done after reset");

  // Commands other than search report done in the next cycle and never raise busy.
  a_short_cmd: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command != CMD_SEARCH) |=> done && !busy)
    else $error("non-search command did not report next cycle");

  // A clear always reports an empty node.
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command == CMD_CLEAR) |=> position == '0)
    else $error("clear did not report zero keys");

  // A result word ends the search, and found and rejected never coincide.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !(found && rejected))
    else $error("result word while busy or with both flags");

endmodule

bind sorted_key_binary_search skbs_checker #(.MAX_KEYS(MAX_KEYS)) u_skbs_checker (.*);

`default_nettype wire

FILE: tb/sorted_key_binary_search_checker.sv
// Checker that predicts and compares every result word of the key search block.
`timescale 1ns / 1ps

module sorted_key_binary_search_checker
  import skbs_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [CMD_W-1:0]                 command,
  input  logic [KEY_W-1:0]                 key_value,
  input  logic                             done,
  input  logic [$clog2(MAX_KEYS + 1)-1:0]  position,
  input  logic                             found,
  input  logic                             rejected,
  output int                               mismatches,
  output int                               pending
);

  localparam int POS_W = $clog2(MAX_KEYS + 1);
  localparam int IDX_W = $clog2(MAX_KEYS);

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic             rejected;
  } node_result_t;

  logic [KEY_W-1:0] node_keys [MAX_KEYS];
  logic [POS_W-1:0] key_count;
  node_result_t     awaited_results [$];

  // Updates the node for one command word and returns the result it gives.
  function automatic node_result_t apply_node_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [KEY_W-1:0] key);
    node_result_t res;
    int           lo;
    int           hi;
    int           mid;
    bit           hit;
    res = '0;
    res.position = key_count;
    case (cmd)
      CMD_CLEAR: begin
        key_count = '0;
        res.position = '0;
      end
      CMD_APPEND: begin
        if (int'(key_count) < MAX_KEYS) begin
          node_keys[key_count[IDX_W-1:0]] = key;
          key_count = key_count + 1'b1;
        end else begin
          res.rejected = 1'b1;
        end
        res.position = key_count;
      end
      CMD_SEARCH: begin
        lo = 0;
        hi = (int'(key_count) > MAX_KEYS) ? MAX_KEYS : int'(key_count);
        hit = 1'b0;
        while (lo != hi && !hit) begin
          mid = lo + (hi - lo) / 2;
          if (key == node_keys[mid]) begin
            hit = 1'b1;
            lo = mid;
          end else if (key < node_keys[mid]) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        res.position = POS_W'(lo);
        res.found = hit;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 10) begin
      $display("%0t: %s", $realtime, what);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    node_result_t want;
    if (rst) begin
      key_count = '0;
      awaited_results.delete();
      mismatches = 0;
      pending = 0;
    end else begin
      // A result word can never belong to a command taken at the same edge,
      // so the comparison goes first.
      if (done) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word: position %0d found %0b rejected %0b",
                                    position, found, rejected));
        end else begin
          want = awaited_results.pop_front();
          if (position !== want.position || found !== want.found ||
              rejected !== want.rejected) begin
            report_mismatch($sformatf({"result word mismatch: expected position %0d found %0b ",
                                       "rejected %0b, got position %0d found %0b rejected %0b"},
                                      want.position, want.found, want.rejected,
                                      position, found, rejected));
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(apply_node_command(command, key_value));
      end
      pending = awaited_results.size();
    end
  end

endmodule

FILE: tb/tb_sorted_key_binary_search.sv
// Testbench top that drives command words into the key search block and gives the verdict.
`timescale 1ns / 1ps

module tb_sorted_key_binary_search;
  import skbs_pkg::*;

  localparam int NODE_KEYS = MAX_KEYS_DEF;
  localparam int POS_W = $clog2(NODE_KEYS + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key_value;
  logic             done;
  logic [POS_W-1:0] position;
  logic             found;
  logic             rejected;
  int               mismatches;
  int               pending;

  int               idle_pct;
  int               words_sent;
  logic [KEY_W-1:0] stored_keys [$];

  sorted_key_binary_search #(.MAX_KEYS(NODE_KEYS)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .key_value (key_value),
    .done      (done),
    .position  (position),
    .found     (found),
    .rejected  (rejected)
  );

  sorted_key_binary_search_checker #(.MAX_KEYS(NODE_KEYS)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .key_value  (key_value),
    .done       (done),
    .position   (position),
    .found      (found),
    .rejected   (rejected),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called just after a rising edge; returns just after the edge that takes the word.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    key_value <= key;
    // busy only moves on rising edges, so its value at the falling edge holds at the next one.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    words_sent++;
    case (cmd)
      CMD_CLEAR: stored_keys.delete();
      CMD_APPEND: if (stored_keys.size() < NODE_KEYS) stored_keys.push_back(key);
      default: begin
      end
    endcase
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_search_key();
    logic [KEY_W-1:0] near;
    int               sel;
    sel = $urandom_range(7);
    near = (stored_keys.size() > 0) ? stored_keys[$urandom_range(stored_keys.size() - 1)]
                                    : $urandom;
    case (sel)
      0, 1, 2: return near;
      3: return near + 1'b1;
      4: return near - 1'b1;
      5: return '0;
      6: return '1;
      default: return $urandom;
    endcase
  endfunction

  // A clear, an ascending fill, then a burst of searches with a stray word now and then.
  task automatic run_node_sequence();
    logic [32:0] next_key;
    logic [32:0] gap;
    int          fill;
    int          mode;
    send_word(CMD_CLEAR, $urandom);
    fill = ($urandom_range(3) == 0) ? $urandom_range(14, NODE_KEYS + 2)
                                    : $urandom_range(0, NODE_KEYS);
    mode = $urandom_range(2);
    case (mode)
      0: next_key = 33'($urandom_range(4));
      1: next_key = 33'($urandom >> $urandom_range(1, 8));
      default: next_key = 33'(32'hFFFF_FFFF - $urandom_range(40));
    endcase
    for (int i = 0; i < fill; i++) begin
      send_word(CMD_APPEND, next_key[KEY_W-1:0]);
      case (mode)
        0: gap = 33'($urandom_range(3));
        1: gap = 33'($urandom >> $urandom_range(5, 12));
        default: gap = 33'($urandom_range(5));
      endcase
      next_key = next_key + gap;
      if (next_key[32]) next_key = 33'h0_FFFF_FFFF;
    end
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(9))
        0: send_word(CMD_UNUSED, $urandom);
        1: send_word(CMD_APPEND, $urandom);
        default: send_word(CMD_SEARCH, pick_search_key());
      endcase
    end
  endtask

  task automatic run_random_words(input int word_goal);
    while (words_sent < word_goal) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 6)) send_word(CMD_W'($urandom_range(3)), $urandom);
      end else begin
        run_node_sequence();
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = CMD_CLEAR;
    key_value = '0;
    idle_pct = 0;
    words_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed words: empty node, unused code, key extremes, a duplicate, an unsorted node.
    send_word(CMD_CLEAR, '0);
    send_word(CMD_SEARCH, 32'h1234_5678);
    send_word(CMD_UNUSED, '1);
    send_word(CMD_APPEND, '0);
    send_word(CMD_APPEND, 32'h7FFF_FFFF);
    send_word(CMD_APPEND, '1);
    send_word(CMD_SEARCH, '0);
    send_word(CMD_SEARCH, '1);
    send_word(CMD_SEARCH, 32'd5);
    send_word(CMD_SEARCH, 32'h8000_0000);
    send_word(CMD_APPEND, '1);
    send_word(CMD_SEARCH, '1);
    send_word(CMD_UNUSED, 32'h5555_AAAA);
    send_word(CMD_CLEAR, '1);
    send_word(CMD_APPEND, 32'd10);
    send_word(CMD_APPEND, 32'd5);
    send_word(CMD_SEARCH, 32'd5);
    send_word(CMD_SEARCH, 32'd7);
    wait_for_results();

    idle_pct = 18;
    run_random_words(words_sent + 430);
    wait_for_results();
    idle_pct = 59;
    run_random_words(words_sent + 430);
    wait_for_results();
    idle_pct = 0;
    run_random_words(words_sent + 440);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sorted_key_binary_search.f
rtl/skbs_pkg.sv
rtl/skbs_key_mem.sv
rtl/skbs_ctrl.sv
rtl/sorted_key_binary_search.sv
rtl/skbs_checker.sv
tb/sorted_key_binary_search_checker.sv
tb/tb_sorted_key_binary_search.sv
